@@ hw/rtl/qte_pkg.sv @@
// Shared types, constants and the arctangent table for the quaternion to Euler angle block.
`default_nettype none
package qte_pkg;

  // Width of the CORDIC vector datapath and of the angle accumulator.
  localparam int XW = 38;
  localparam int ZW = 34;
  localparam int ANG_TABLE_LEN = 24;
  localparam int SQRT_STEPS = 29;

  localparam logic signed [ZW-1:0] ANG_180 = 34'sd1179648000;
  localparam logic signed [33:0] Q28_ONE = 34'sd268435456;
  localparam logic signed [19:0] ROLL_LIM = 20'sd9000;
  localparam logic signed [19:0] HEAD_LIM = 20'sd18000;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
  } in_t;

  typedef struct packed {
    logic signed [14:0] roll_cdeg;
    logic signed [15:0] pitch_cdeg;
    logic signed [15:0] yaw_cdeg;
    logic               clamped;
  } out_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  // Data that rides alongside the square root chain.
  typedef struct packed {
    logic                 clamped;
    logic signed [29:0]   a;
    logic signed [XW-1:0] px;
    logic signed [XW-1:0] py;
    logic signed [XW-1:0] yx;
    logic signed [XW-1:0] yy;
  } side_t;

  // atan(2^-i) in units of 0.01 deg / 65536.
  function automatic logic signed [ZW-1:0] atan_unit(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 34'sd294912000;
      1:  r = 34'sd174096719;
      2:  r = 34'sd91987925;
      3:  r = 34'sd46694507;
      4:  r = 34'sd23437865;
      5:  r = 34'sd11730358;
      6:  r = 34'sd5866610;
      7:  r = 34'sd2933484;
      8:  r = 34'sd1466764;
      9:  r = 34'sd733385;
      10: r = 34'sd366693;
      11: r = 34'sd183346;
      12: r = 34'sd91673;
      13: r = 34'sd45837;
      14: r = 34'sd22918;
      15: r = 34'sd11459;
      16: r = 34'sd5730;
      17: r = 34'sd2865;
      18: r = 34'sd1432;
      19: r = 34'sd716;
      20: r = 34'sd358;
      21: r = 34'sd179;
      22: r = 34'sd90;
      23: r = 34'sd45;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/qte_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
`default_nettype none
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int K = 0
) (
  input  wire logic        clk,
  input  wire logic [56:0] n_i,
  input  wire logic [57:0] res_i,
  output logic [56:0]      n_o,
  output logic [57:0]      res_o
);

  localparam logic [57:0] BIT = 58'd1 << (2 * K);

  logic [57:0] trial;
  logic [57:0] n_ext;
  logic        take;
  logic [56:0] n_nxt;
  logic [57:0] res_nxt;

  assign trial = res_i + BIT;
  assign n_ext = {1'b0, n_i};
  assign take  = n_ext >= trial;

  always_comb begin
    if (take) begin
      n_nxt   = 57'(n_ext - trial);
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      n_nxt   = n_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    n_o   <= n_nxt;
    res_o <= res_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/qte_cordic_cell.sv @@
// One vectoring rotation of the CORDIC chain.
`default_nettype none
module qte_cordic_cell import qte_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire logic clk,
  input  wire vec_t v_i,
  output vec_t      v_o
);

  localparam logic signed [ZW-1:0] STEP_ANG = atan_unit(SHIFT);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  vec_t                 v_nxt;

  assign xs = v_i.x >>> SHIFT;
  assign ys = v_i.y >>> SHIFT;

  always_comb begin
    v_nxt.zero = v_i.zero;
    if (v_i.y > 0) begin
      v_nxt.x = v_i.x + ys;
      v_nxt.y = v_i.y - xs;
      v_nxt.z = v_i.z + STEP_ANG;
    end else begin
      v_nxt.x = v_i.x - ys;
      v_nxt.y = v_i.y + xs;
      v_nxt.z = v_i.z - STEP_ANG;
    end
  end

  always_ff @(posedge clk) begin
    v_o <= v_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/quaternion_to_euler_angles.sv @@
// Top level: quaternion to roll, pitch and yaw in hundredths of a degree.
//
// Usage: drive in_data with a Q2.14 quaternion and raise start for one cycle
// per transaction. busy is always low, so a new quaternion can be presented in
// every cycle. Each transaction gives exactly one result on out_data, shown
// for a single cycle with out_valid high.
// CORDIC_STEPS above 24 counts as 24. Throughput is one transaction per cycle:
// every stage is registered, the 29 square root cells and the CORDIC cells each
// pass their data to the next cell in every cycle, with three CORDIC lanes working
// side by side.
// The receiver cannot stall; results are simply presented in order.
// Reset clears the valid pipeline, so no stale strobe appears after reset;
// datapath registers are not reset.
// The arcsine is formed as atan2(a, sqrt(1 - a^2)) with a clamped to +-1,
// and out_data.clamped reports when that clamp was applied.
`default_nettype none
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int NSTEP = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STEPS;
  localparam int PRE = 4 + SQRT_STEPS;
  localparam int TOT = PRE + NSTEP + 2;

  logic [TOT-1:0] vld_r;
  in_t            in_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TOT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      in_r <= in_data;
    end
  end

  // Products of the quaternion parts.
  logic signed [31:0] wx_r, yz_r, xz_r, wy_r, xy_r, wz_r, ww_r, xx_r, yy_r, zz_r;

  always_ff @(posedge clk) begin
    wx_r <= in_r.q_w * in_r.q_x;
    yz_r <= in_r.q_y * in_r.q_z;
    xz_r <= in_r.q_x * in_r.q_z;
    wy_r <= in_r.q_w * in_r.q_y;
    xy_r <= in_r.q_x * in_r.q_y;
    wz_r <= in_r.q_w * in_r.q_z;
    ww_r <= in_r.q_w * in_r.q_w;
    xx_r <= in_r.q_x * in_r.q_x;
    yy_r <= in_r.q_y * in_r.q_y;
    zz_r <= in_r.q_z * in_r.q_z;
  end

  // Sums, and the clamp of the arcsine argument.
  logic signed [33:0] a_raw;
  logic signed [29:0] a_nxt;
  logic               cl_nxt;
  side_t              s3_r;

  assign a_raw = 34'(2 * (34'(xz_r) - 34'(wy_r)));

  always_comb begin
    if (a_raw > Q28_ONE) begin
      a_nxt  = 30'(Q28_ONE);
      cl_nxt = 1'b1;
    end else if (a_raw < -Q28_ONE) begin
      a_nxt  = 30'(-Q28_ONE);
      cl_nxt = 1'b1;
    end else begin
      a_nxt  = 30'(a_raw);
      cl_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s3_r.clamped <= cl_nxt;
    s3_r.a       <= a_nxt;
    s3_r.py      <= XW'(2 * (34'(wx_r) + 34'(yz_r)));
    s3_r.px      <= XW'(34'(ww_r) - 34'(xx_r) - 34'(yy_r) + 34'(zz_r));
    s3_r.yy      <= XW'(2 * (34'(xy_r) + 34'(wz_r)));
    s3_r.yx      <= XW'(34'(ww_r) + 34'(xx_r) - 34'(yy_r) - 34'(zz_r));
  end

  // Radicand 2^56 - a^2.
  logic signed [59:0] asq;
  logic [56:0]        n_r;
  side_t              side_s [SQRT_STEPS+1];

  assign asq = s3_r.a * s3_r.a;

  always_ff @(posedge clk) begin
    n_r       <= 57'(60'sd72057594037927936 - asq);
    side_s[0] <= s3_r;
  end

  logic [56:0] n_s   [SQRT_STEPS+1];
  logic [57:0] res_s [SQRT_STEPS+1];

  assign n_s[0]   = n_r;
  assign res_s[0] = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    qte_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_cell (
      .clk   (clk),
      .n_i   (n_s[j]),
      .res_i (res_s[j]),
      .n_o   (n_s[j+1]),
      .res_o (res_s[j+1])
    );
    always_ff @(posedge clk) begin
      side_s[j+1] <= side_s[j];
    end
  end

  // Quadrant fold of the three vectors ahead of the CORDIC lanes.
  function automatic vec_t fold(input logic signed [XW-1:0] y, input logic signed [XW-1:0] x);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      v.x = -x;
      v.y = -y;
      v.z = (y >= 0) ? ANG_180 : -ANG_180;
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  side_t                sq_side;
  logic signed [XW-1:0] root;
  vec_t                 pre_r [3];
  logic                 cl_r  [NSTEP+1];

  assign sq_side = side_s[SQRT_STEPS];
  assign root    = XW'($signed({1'b0, res_s[SQRT_STEPS][28:0]}));

  always_ff @(posedge clk) begin
    pre_r[0] <= fold(XW'(sq_side.a), root);
    pre_r[1] <= fold(sq_side.py, sq_side.px);
    pre_r[2] <= fold(sq_side.yy, sq_side.yx);
    cl_r[0]  <= sq_side.clamped;
  end

  vec_t cv [3][NSTEP+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign cv[l][0] = pre_r[l];
    for (genvar j = 0; j < NSTEP; j++) begin : g_step
      qte_cordic_cell #(.SHIFT(j)) u_cell (
        .clk (clk),
        .v_i (cv[l][j]),
        .v_o (cv[l][j+1])
      );
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_cl
    always_ff @(posedge clk) begin
      cl_r[j+1] <= cl_r[j];
    end
  end

  // Round to 0.01 deg, negate and saturate; a zero vector gives zero.
  function automatic logic signed [19:0] finish(input vec_t v, input logic signed [19:0] lim);
    logic signed [ZW-1:0] zr;
    logic signed [19:0]   d;
    zr = (v.z + 34'sd32768) >>> 16;
    d  = -20'(zr);
    if (v.zero) begin
      d = '0;
    end else if (d > lim) begin
      d = lim;
    end else if (d < -lim) begin
      d = -lim;
    end
    return d;
  endfunction

  logic signed [19:0] roll_f, pitch_f, yaw_f;

  assign roll_f  = finish(cv[0][NSTEP], ROLL_LIM);
  assign pitch_f = finish(cv[1][NSTEP], HEAD_LIM);
  assign yaw_f   = finish(cv[2][NSTEP], HEAD_LIM);

  always_ff @(posedge clk) begin
    out_data.roll_cdeg  <= roll_f[14:0];
    out_data.pitch_cdeg <= pitch_f[15:0];
    out_data.yaw_cdeg   <= yaw_f[15:0];
    out_data.clamped    <= cl_r[NSTEP];
  end

  assign out_valid = vld_r[TOT-1];

endmodule
`default_nettype wire
